// File: design/brf_pkg.sv
package brf_pkg;

  // Ring geometry and burst limit
  localparam int DEPTH     = 256;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int MAX_BURST = 64;

  // Field widths fixed by the interface
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 8;
  localparam int LEN_W   = 7;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 8;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 3'd0,
    OP_GET     = 3'd1,
    OP_DISCARD = 3'd2,
    OP_PEEK    = 3'd3,
    OP_FLUSH   = 3'd4,
    OP_BREAD   = 3'd5,
    OP_BSKIP   = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] wr_byte;
    logic [INDEX_W-1:0] peek_index;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // One result item
  typedef struct packed {
    stat_t             status;
    logic [BYTE_W-1:0] rd_byte;
    logic [LEN_W-1:0]  granted;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  room_count;
    logic              last;
  } res_t;

  // Fit a pointer-wide count into the reported count width
  function automatic logic [CNT_W-1:0] cnt_fit(ptr_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[CNT_W-1:0];
  endfunction

endpackage

// File: design/byte_ring_fifo_with_peek.sv
// Channel | Handshake               | Payload
// in      | in_valid / in_stall     | in_op, in_wr_byte, in_peek_index, in_burst_len
// out     | out_valid / out_stall   | out_status, out_rd_byte, out_granted,
//         |                         | out_used_count, out_room_count, out_last
//
// Put, discard, flush, skip, nop and any empty or full miss load the result register directly.
// Get and a peek hit go through the ring RAM read port, which is registered, before the result loads.
// A burst read of N bytes gives one result per cycle after the first while the output is not stalled.
// Synchronous active-low reset empties the ring; stored bytes are not cleared.
// A two-request queue lets new requests in while the result register is stalled.
module byte_ring_fifo_with_peek
  import brf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic [BYTE_W-1:0]  in_wr_byte,
  input  logic [INDEX_W-1:0] in_peek_index,
  input  logic [LEN_W-1:0]   in_burst_len,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [BYTE_W-1:0]  out_rd_byte,
  output logic [LEN_W-1:0]   out_granted,
  output logic [CNT_W-1:0]   out_used_count,
  output logic [CNT_W-1:0]   out_room_count,
  output logic               out_last
);

  logic q_full, push, pop, q_valid;
  cmd_t cmd_in, cmd_out;
  res_t res;

  brf_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_wr_byte    (in_wr_byte),
    .in_peek_index (in_peek_index),
    .in_burst_len  (in_burst_len),
    .q_full        (q_full),
    .push          (push),
    .cmd           (cmd_in)
  );

  brf_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_in),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .cmd_out (cmd_out)
  );

  brf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .cmd       (cmd_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Unpack the result register onto the ports
  assign out_status     = res.status;
  assign out_rd_byte    = res.rd_byte;
  assign out_granted    = res.granted;
  assign out_used_count = res.used_count;
  assign out_room_count = res.room_count;
  assign out_last       = res.last;

endmodule

// File: design/brf_front.sv
module brf_front
  import brf_pkg::*;
(
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic [BYTE_W-1:0]  in_wr_byte,
  input  logic [INDEX_W-1:0] in_peek_index,
  input  logic [LEN_W-1:0]   in_burst_len,
  input  logic               q_full,
  output logic               push,
  output cmd_t               cmd
);

  // Hold off new requests while the queue is full
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Decode the operation and cap the burst length
  always_comb begin
    cmd.op         = op_t'(in_op);
    cmd.wr_byte    = in_wr_byte;
    cmd.peek_index = in_peek_index;
    if (in_burst_len > LEN_W'(MAX_BURST)) begin
      cmd.len = LEN_W'(MAX_BURST);
    end else begin
      cmd.len = in_burst_len;
    end
  end

endmodule

// File: design/brf_cmdq.sv
module brf_cmdq
  import brf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t cmd_out
);

  cmd_t            slot_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == QC_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign cmd_out = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Advance pointers and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: design/brf_back.sv
module brf_back
  import brf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output res_t res
);

  back_state_t       state_r, state_nxt;
  ptr_t              head_r, head_nxt;
  ptr_t              tail_r, tail_nxt;
  ptr_t              pend_used_r, pend_used_nxt;
  logic [LEN_W-1:0]  pend_granted_r, pend_granted_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              out_valid_r;
  res_t              res_r;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q;

  ptr_t              used;
  ptr_t              used_src;
  logic              out_free;
  logic [LEN_W-1:0]  grant;
  logic              wr_en, rd_en, load, use_pend;
  ptr_t              rd_addr;
  res_t              res_new;

  assign used     = tail_r - head_r;
  assign out_free = !out_valid_r || !out_stall;
  assign grant    = (32'(cmd.len) < 32'(used)) ? cmd.len : LEN_W'(used);

  // Sequence each request: immediate ops emit at once, reads go through the RAM
  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    pend_used_nxt    = pend_used_r;
    pend_granted_nxt = pend_granted_r;
    rem_nxt          = rem_r;
    pop              = 1'b0;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = head_r;
    load             = 1'b0;
    use_pend         = 1'b0;
    res_new          = '0;
    res_new.status   = STAT_OK;
    res_new.last     = 1'b1;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          unique case (cmd.op)
            OP_PUT: begin
              load = 1'b1;
              if (used != '1) begin
                wr_en    = 1'b1;
                tail_nxt = tail_r + 1'b1;
              end else begin
                res_new.status = STAT_FULL;
              end
            end
            OP_GET, OP_DISCARD: begin
              if (used == '0) begin
                load           = 1'b1;
                res_new.status = STAT_EMPTY;
              end else begin
                head_nxt = head_r + 1'b1;
                if (cmd.op == OP_GET) begin
                  rd_en            = 1'b1;
                  pend_used_nxt    = used - 1'b1;
                  pend_granted_nxt = '0;
                  rem_nxt          = '0;
                  state_nxt        = B_READ;
                end else begin
                  load = 1'b1;
                end
              end
            end
            OP_PEEK: begin
              if (32'(cmd.peek_index) < 32'(used)) begin
                rd_en            = 1'b1;
                rd_addr          = head_r + ptr_t'(cmd.peek_index);
                pend_used_nxt    = used;
                pend_granted_nxt = '0;
                rem_nxt          = '0;
                state_nxt        = B_READ;
              end else begin
                load           = 1'b1;
                res_new.status = STAT_EMPTY;
              end
            end
            OP_FLUSH: begin
              load     = 1'b1;
              head_nxt = tail_r;
            end
            OP_BREAD, OP_BSKIP: begin
              if (grant == '0) begin
                load           = 1'b1;
                res_new.status = STAT_EMPTY;
              end else if (cmd.op == OP_BSKIP) begin
                load            = 1'b1;
                head_nxt        = head_r + ptr_t'(grant);
                res_new.granted = grant;
              end else begin
                rd_en            = 1'b1;
                head_nxt         = head_r + 1'b1;
                pend_used_nxt    = used - 1'b1;
                pend_granted_nxt = grant;
                rem_nxt          = grant - 1'b1;
                state_nxt        = B_READ;
              end
            end
            OP_NOP: begin
              load = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        if (out_free) begin
          load            = 1'b1;
          use_pend        = 1'b1;
          res_new.rd_byte = mem_q;
          res_new.granted = pend_granted_r;
          res_new.last    = (rem_r == '0);
          // Issue the next burst byte while this one leaves
          if (rem_r != '0) begin
            rd_en         = 1'b1;
            head_nxt      = head_r + 1'b1;
            rem_nxt       = rem_r - 1'b1;
            pend_used_nxt = pend_used_r - 1'b1;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
    endcase

    // Report counts as they stand after this result
    used_src           = use_pend ? pend_used_r : (tail_nxt - head_nxt);
    res_new.used_count = cnt_fit(used_src);
    res_new.room_count = cnt_fit(~used_src);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold burst bookkeeping and the result register
  always_ff @(posedge clk) begin
    pend_used_r    <= pend_used_nxt;
    pend_granted_r <= pend_granted_nxt;
    rem_r          <= rem_nxt;
    if (load) begin
      res_r <= res_new;
    end
  end

  // Ring storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= cmd.wr_byte;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
